// ===== rtl/piaw_pkg.sv =====
// Shared types, register codes and saturation helpers for the PI regulator.
`default_nettype none

package piaw_pkg;

  localparam int ErrW     = 16;
  localparam int GainW    = 16;
  localparam int ShW      = 4;
  localparam int LimW     = 16;
  localparam int AccW     = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int OutDataW = 2 * AccW;

  localparam logic signed [AccW-1:0] AccMax = 32'sh7FFF_FFFF;
  localparam logic signed [AccW-1:0] AccMin = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP_GAIN = 3'd0,
    CFG_KI_GAIN = 3'd1,
    CFG_P_SHIFT = 3'd2,
    CFG_I_SHIFT = 3'd3,
    CFG_OUT_MAX = 3'd4,
    CFG_OUT_MIN = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [GainW-1:0] kp_gain;
    logic signed [GainW-1:0] ki_gain;
    logic [ShW-1:0]          p_shift;
    logic [ShW-1:0]          i_shift;
    logic signed [LimW-1:0]  out_max;
    logic signed [LimW-1:0]  out_min;
  } cfg_t;

  // Scaled gain products handed from the gain stage to the integrator stage
  typedef struct packed {
    logic signed [AccW-1:0] pterm;
    logic signed [AccW-1:0] iterm;
    logic                   p_above;
    logic                   p_below;
  } terms_t;

  // Limit register scaled by 2^16
  function automatic logic signed [AccW-1:0] lim_scale(input logic signed [LimW-1:0] lim);
    lim_scale = $signed({lim, {(AccW-LimW){1'b0}}});
  endfunction

  // Saturate a one-bit-grown sum back to 32 bits
  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [AccW:0] v);
    if (v[AccW] != v[AccW-1]) begin
      sat_acc = v[AccW] ? AccMin : AccMax;
    end else begin
      sat_acc = $signed(v[AccW-1:0]);
    end
  endfunction

  // Upper limit tested first, so values above it take it even when the limits are crossed
  function automatic logic signed [AccW-1:0] clamp_acc(input logic signed [AccW-1:0] v,
                                                      input logic signed [AccW-1:0] hi,
                                                      input logic signed [AccW-1:0] lo);
    if (v > hi) begin
      clamp_acc = hi;
    end else if (v < lo) begin
      clamp_acc = lo;
    end else begin
      clamp_acc = v;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/piaw_cfg.sv =====
// Configuration register file for gains, shifts and output limits.
`default_nettype none

module piaw_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [piaw_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [piaw_pkg::CfgDataW-1:0] cfg_data,
  output piaw_pkg::cfg_t                     cfg
);
  import piaw_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain <= '0;
      cfg.ki_gain <= '0;
      cfg.p_shift <= '0;
      cfg.i_shift <= '0;
      cfg.out_max <= 16'sh7FFF;
      cfg.out_min <= 16'sh8000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KP_GAIN: cfg.kp_gain <= $signed(cfg_data[GainW-1:0]);
        CFG_KI_GAIN: cfg.ki_gain <= $signed(cfg_data[GainW-1:0]);
        CFG_P_SHIFT: cfg.p_shift <= cfg_data[ShW-1:0];
        CFG_I_SHIFT: cfg.i_shift <= cfg_data[ShW-1:0];
        CFG_OUT_MAX: cfg.out_max <= $signed(cfg_data[LimW-1:0]);
        CFG_OUT_MIN: cfg.out_min <= $signed(cfg_data[LimW-1:0]);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/piaw_gain.sv =====
// Gain stage: both products, their clamps and scaling shifts, and limit flags.
`default_nettype none

module piaw_gain (
  input  wire logic                               clk,
  input  wire logic                               load,
  input  wire logic signed [piaw_pkg::ErrW-1:0]   error,
  input  piaw_pkg::cfg_t                          cfg,
  output piaw_pkg::terms_t                        terms
);
  import piaw_pkg::*;

  logic signed [GainW-1:0] kp;
  logic signed [GainW-1:0] ki;
  logic [ShW:0]            ps;
  logic signed [AccW-1:0]  prod_p;
  logic signed [AccW-1:0]  prod_i;
  logic signed [AccW-1:0]  pb;
  logic signed [AccW-1:0]  ib;
  logic signed [AccW-1:0]  pclamp;
  logic signed [AccW-1:0]  iclamp;
  terms_t                  terms_next;

  assign kp = cfg.kp_gain;
  assign ki = cfg.ki_gain;
  assign ps = {1'b0, cfg.p_shift} + (ShW+1)'(4);

  assign prod_p = kp * error;
  assign prod_i = ki * error;

  assign pb = $signed(AccMax >> ps);
  assign ib = $signed(AccMax >> cfg.i_shift);

  assign pclamp = (prod_p > pb) ? pb : ((prod_p < -pb) ? -pb : prod_p);
  assign iclamp = (prod_i > ib) ? ib : ((prod_i < -ib) ? -ib : prod_i);

  always_comb begin
    terms_next.pterm   = pclamp <<< ps;
    terms_next.iterm   = iclamp <<< cfg.i_shift;
    terms_next.p_above = terms_next.pterm > lim_scale(cfg.out_max);
    terms_next.p_below = terms_next.pterm < lim_scale(cfg.out_min);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      terms <= terms_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/piaw_integ.sv =====
// Integrator stage: bleed or accumulate, saturating sums, output and integrator clamps.
`default_nettype none

module piaw_integ (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              load,
  input  piaw_pkg::terms_t                       terms,
  input  piaw_pkg::cfg_t                         cfg,
  output logic signed [piaw_pkg::AccW-1:0]       drive,
  output logic signed [piaw_pkg::AccW-1:0]       integrator
);
  import piaw_pkg::*;

  logic signed [AccW-1:0] hi;
  logic signed [AccW-1:0] lo;
  logic                   i_pos;
  logic                   i_neg;
  logic signed [AccW-1:0] i_shr;
  logic signed [AccW-1:0] base;
  logic signed [AccW-1:0] inc;
  logic signed [AccW-1:0] sum_i;
  logic signed [AccW-1:0] sum_d;
  logic signed [AccW-1:0] drive_next;
  logic signed [AccW-1:0] integrator_next;

  assign hi    = lim_scale(cfg.out_max);
  assign lo    = lim_scale(cfg.out_min);
  assign i_pos = !integrator[AccW-1] && (|integrator);
  assign i_neg = integrator[AccW-1];
  assign i_shr = integrator >>> 8;

  // Bleed toward zero while pterm alone is past the limit on the integrator's side
  always_comb begin
    if (terms.p_above && i_pos) begin
      base = integrator - i_shr - AccW'(1);
      inc  = '0;
    end else if (terms.p_below && i_neg) begin
      base = integrator - i_shr + AccW'(1);
      inc  = '0;
    end else begin
      base = integrator;
      inc  = terms.iterm;
    end
  end

  assign sum_i = sat_acc({base[AccW-1], base} + {inc[AccW-1], inc});
  assign sum_d = sat_acc({sum_i[AccW-1], sum_i} + {terms.pterm[AccW-1], terms.pterm});

  assign drive_next      = clamp_acc(sum_d, hi, lo);
  assign integrator_next = clamp_acc(sum_i, hi, lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
    end else if (load) begin
      integrator <= integrator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive <= drive_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pi_regulator_anti_windup.sv =====
// Top level of the PI regulator with anti-windup: stream ports, stage control, checks.
`default_nettype none

// PI regulator with anti-windup. Each error sample on the input stream yields one
// result carrying the clamped drive value and the integrator after its clamp. The
// block takes one sample per clock unless the output stalls; each sample passes
// three registered stages (input register, gain products, integrator update).
// The integrator update sets the rate: it reads the integrator and writes its new
// value in the same cycle, so samples follow one another without a gap. A stalled
// output holds the pipeline; up to three samples are in flight. Configuration registers
// are written through the plain write port and take effect for the next sample.
module pi_regulator_anti_windup (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [piaw_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire logic [piaw_pkg::CfgDataW-1:0]      cfg_data,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [piaw_pkg::ErrW-1:0]          s_axis_tdata,  // [15:0] error
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [piaw_pkg::OutDataW-1:0]           m_axis_tdata   // [31:0] drive_out,
                                                                 // [63:32] integrator_value
);
  import piaw_pkg::*;

  cfg_t                   cfg;
  terms_t                 terms;
  logic signed [ErrW-1:0] err_q;
  logic                   s0_valid;
  logic                   s1_valid;
  logic                   s0_en;
  logic                   s1_en;
  logic                   out_en;
  logic                   gain_load;
  logic                   integ_load;
  logic signed [AccW-1:0] drive;
  logic signed [AccW-1:0] integrator;

  // Advance a stage when it is empty or the stage after it advances
  assign out_en     = !m_axis_tvalid || m_axis_tready;
  assign s1_en      = !s1_valid || out_en;
  assign s0_en      = !s0_valid || s1_en;
  assign gain_load  = s1_en && s0_valid;
  assign integ_load = out_en && s1_valid;

  assign s_axis_tready = s0_en;
  assign m_axis_tdata  = {integrator, drive};

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid      <= 1'b0;
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s0_en) begin
        s0_valid <= s_axis_tvalid;
      end
      if (s1_en) begin
        s1_valid <= s0_valid;
      end
      if (out_en) begin
        m_axis_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_en && s_axis_tvalid) begin
      err_q <= $signed(s_axis_tdata);
    end
  end

  piaw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  piaw_gain u_gain (
    .clk   (clk),
    .load  (gain_load),
    .error (err_q),
    .cfg   (cfg),
    .terms (terms)
  );

  piaw_integ u_integ (
    .clk        (clk),
    .rst        (rst),
    .load       (integ_load),
    .terms      (terms),
    .cfg        (cfg),
    .drive      (drive),
    .integrator (integrator)
  );

  // A freshly computed drive lies within the limits in force, when they are not crossed
  a_drive_in_limits: assert property (@(posedge clk) disable iff (rst)
    $past(integ_load) && !$past(rst) && ($past(cfg.out_min) <= $past(cfg.out_max)) |->
      (drive <= lim_scale($past(cfg.out_max))) && (drive >= lim_scale($past(cfg.out_min))))
    else $error("drive outside output limits");

  // The integrator is clamped to the same limits on every update
  a_integ_in_limits: assert property (@(posedge clk) disable iff (rst)
    $past(integ_load) && !$past(rst) && ($past(cfg.out_min) <= $past(cfg.out_max)) |->
      (integrator <= lim_scale($past(cfg.out_max))) &&
      (integrator >= lim_scale($past(cfg.out_min))))
    else $error("integrator outside output limits");

  // A gain-stage result held back by a stalled output is not dropped
  a_gain_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_en |=> s1_valid && $stable(terms))
    else $error("gain stage lost a request");

  // Reset clears the integrator and empties the output
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (integrator == '0) && !m_axis_tvalid && !s0_valid && !s1_valid)
    else $error("reset did not clear integrator state");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for the PI regulator with anti-windup: random stream traffic and register sets.
import piaw_pkg::*;

typedef struct {
  logic signed [AccW-1:0] drive;
  logic signed [AccW-1:0] integ;
} drive_pair_t;

class pi_loop_calc;
  logic signed [GainW-1:0] kp;
  logic signed [GainW-1:0] ki;
  logic [ShW-1:0]          p_sh;
  logic [ShW-1:0]          i_sh;
  logic signed [LimW-1:0]  lim_hi;
  logic signed [LimW-1:0]  lim_lo;
  logic signed [AccW-1:0]  integ;
  drive_pair_t             expected_drive[$];
  int unsigned             bad_fields;

  function new();
    kp         = '0;
    ki         = '0;
    p_sh       = '0;
    i_sh       = '0;
    lim_hi     = 16'sh7FFF;
    lim_lo     = 16'sh8000;
    integ      = '0;
    bad_fields = 0;
  endfunction

  function longint sat32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // Upper bound tested first, so it wins for values above it when the bounds are crossed
  function longint bound(longint v, longint up, longint dn);
    if (v > up) return up;
    if (v < dn) return dn;
    return v;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CFG_KP_GAIN: kp     = data;
      CFG_KI_GAIN: ki     = data;
      CFG_P_SHIFT: p_sh   = data[ShW-1:0];
      CFG_I_SHIFT: i_sh   = data[ShW-1:0];
      CFG_OUT_MAX: lim_hi = data;
      CFG_OUT_MIN: lim_lo = data;
      default: ;
    endcase
  endfunction

  function void take_error(logic [ErrW-1:0] raw);
    longint err, kp_l, ki_l, up, dn, pb, ib, pterm, iterm, acc, drv;
    int unsigned ps;
    drive_pair_t r;
    err   = $signed(raw);
    kp_l  = kp;
    ki_l  = ki;
    up    = longint'(lim_hi) * 65536;
    dn    = longint'(lim_lo) * 65536;
    ps    = 4 + p_sh;
    pb    = longint'(32'h7FFF_FFFF >> ps);
    ib    = longint'(32'h7FFF_FFFF >> i_sh);
    pterm = bound(kp_l * err, pb, -pb) * (longint'(1) << ps);
    iterm = bound(ki_l * err, ib, -ib) * (longint'(1) << i_sh);
    acc   = integ;
    // Bleed the integrator toward zero while the proportional term is past the limit on its side
    if (pterm > up && acc > 0) begin
      acc   = sat32(acc - ((acc >>> 8) + 1));
      iterm = 0;
    end else if (pterm < dn && acc < 0) begin
      acc   = sat32(acc - ((acc >>> 8) - 1));
      iterm = 0;
    end
    acc     = sat32(acc + iterm);
    drv     = bound(sat32(acc + pterm), up, dn);
    acc     = bound(acc, up, dn);
    integ   = acc[AccW-1:0];
    r.drive = drv[AccW-1:0];
    r.integ = integ;
    expected_drive.push_back(r);
  endfunction

  function void check_drive(logic signed [AccW-1:0] drive, logic signed [AccW-1:0] ival);
    drive_pair_t r;
    if (expected_drive.size() == 0) begin
      bad_fields++;
      if (bad_fields <= 200)
        $display("%0t: result with nothing pending: drive %0d integ %0d", $time, drive, ival);
      return;
    end
    r = expected_drive.pop_front();
    if (drive !== r.drive) begin
      bad_fields++;
      if (bad_fields <= 200)
        $display("%0t: drive_out expected %0d actual %0d", $time, r.drive, drive);
    end
    if (ival !== r.integ) begin
      bad_fields++;
      if (bad_fields <= 200)
        $display("%0t: integrator_value expected %0d actual %0d", $time, r.integ, ival);
    end
  endfunction

  function int pending();
    return expected_drive.size();
  endfunction
endclass

module tb;
  localparam logic [CfgIdxW-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] IDX_SPARE_HI = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ErrW-1:0]     s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  bit src_calm = 1'b0;
  bit snk_calm = 1'b0;

  pi_loop_calc calc = new();

  pi_regulator_anti_windup dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) calc.write_reg(cfg_index, cfg_data);
      if (m_axis_tvalid && m_axis_tready)
        calc.check_drive(m_axis_tdata[AccW-1:0], m_axis_tdata[2*AccW-1:AccW]);
      if (s_axis_tvalid && s_axis_tready) calc.take_error(s_axis_tdata);
    end
  end

  function automatic int unsigned draw_gap(bit calm);
    if (calm) return 0;
    return $urandom_range(0, 8);
  endfunction

  // Output side: hold tready low for a random gap before each result, none when calm
  initial begin
    int unsigned gap;
    wait (!rst);
    forever begin
      gap = draw_gap(snk_calm);
      @(negedge clk);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_error(input logic [ErrW-1:0] e);
    int unsigned gap;
    gap = draw_gap(src_calm);
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= e;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Hold the input until every pending result is out and the pipeline is empty
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (calc.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] kp, input logic [15:0] ki,
                                input logic [15:0] ps, input logic [15:0] is_d,
                                input logic [15:0] mx, input logic [15:0] mn);
    settle();
    write_reg(CFG_KP_GAIN, kp);
    write_reg(CFG_KI_GAIN, ki);
    write_reg(CFG_P_SHIFT, ps);
    write_reg(CFG_I_SHIFT, is_d);
    write_reg(CFG_OUT_MAX, mx);
    write_reg(CFG_OUT_MIN, mn);
  endtask

  initial begin
    logic [15:0] kp, ki, ps, is_d, mx, mn, a, b;
    int          val, run_len, kind, sent;
    bit          neg;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Writes beyond the last register must not disturb anything
    write_reg(IDX_SPARE_LO, 16'($urandom));
    write_reg(IDX_SPARE_HI, 16'($urandom));

    // Full gains, shifts beyond range with upper data bits set: saturation everywhere
    apply_settings(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFF0 | 16'd15, 16'h7FFF, 16'h8000);
    send_error(16'h7FFF);
    send_error(16'h7FFF);
    send_error(16'h8000);
    send_error(16'h8000);
    send_error(16'h8000);
    send_error(16'h0000);
    send_error(16'h0001);
    send_error(16'hFFFF);

    // Narrow limits: build up, then bleed on both sides
    apply_settings(16'd1000, 16'd200, 16'd0, 16'd2, 16'd100, -16'sd100);
    send_error(16'd50);
    send_error(16'd50);
    send_error(16'd50);
    send_error(16'd1000);
    send_error(16'd1000);
    send_error(16'd1000);
    send_error(-16'sd1000);
    send_error(-16'sd1000);
    send_error(-16'sd1000);
    send_error(-16'sd50);

    // Crossed limits: the upper limit is tested first
    apply_settings(-16'sd300, 16'd7, 16'd3, 16'd1, -16'sd10, 16'd10);
    send_error(16'd20000);
    send_error(-16'sd20000);
    send_error(16'd5);
    send_error(-16'sd5);
    send_error(16'h7FFF);

    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: apply_settings(16'h8000, 16'h8000, 16'd15, 16'd15, 16'h7FFF, 16'h8000);
        1: apply_settings(16'h7FFF, 16'h7FFF, 16'd0, 16'd0, 16'h8000, 16'h7FFF);
        2: apply_settings(16'h7FFF, 16'h8000, 16'd11, 16'd0, 16'h0000, 16'h0000);
        default: begin
          kp   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1023) - 512)
                                             : 16'($urandom);
          ki   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1023) - 512)
                                             : 16'($urandom);
          ps   = {12'($urandom), 4'(($urandom_range(0, 3) == 0) ? $urandom_range(12, 15)
                                                               : $urandom_range(0, 11))};
          is_d = {12'($urandom), 4'($urandom_range(0, 15))};
          a    = 16'($urandom);
          b    = 16'($urandom);
          case ($urandom_range(0, 9))
            0: begin mx = a; mn = b; end
            1: begin mx = 16'h7FFF; mn = 16'h8000; end
            default: begin
              if ($signed(a) >= $signed(b)) begin mx = a; mn = b; end
              else begin mx = b; mn = a; end
            end
          endcase
          apply_settings(kp, ki, ps, is_d, mx, mn);
        end
      endcase

      sent = 0;
      while (sent < 115) begin
        run_len  = $urandom_range(1, 24);
        kind     = $urandom_range(0, 5);
        neg      = $urandom_range(0, 1);
        src_calm = ($urandom_range(0, 3) == 0);
        snk_calm = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < run_len; k++) begin
          case (kind)
            0: val = $urandom_range(0, 65535) - 32768;
            1: val = neg ? -32768 : 32767;
            2: val = $urandom_range(0, 255);
            3: val = $urandom_range(0, 8191);
            4: val = $urandom_range(0, 1);
            default: val = $urandom_range(0, 32767);
          endcase
          if (kind != 0 && kind != 1 && neg) val = -val;
          send_error(16'(val));
          sent++;
        end
      end
    end

    settle();
    while (calc.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (calc.bad_fields == 0 && calc.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== pi_regulator_anti_windup.f =====
rtl/piaw_pkg.sv
rtl/piaw_cfg.sv
rtl/piaw_gain.sv
rtl/piaw_integ.sv
rtl/pi_regulator_anti_windup.sv
sim/tb.sv
